### rtl/huffman_block_bit_packer_macros.svh
// assertion macros for the huffman block bit packer
// used by the top level only, no other dependencies
`ifndef HUFFMAN_BLOCK_BIT_PACKER_MACROS_SVH
`define HUFFMAN_BLOCK_BIT_PACKER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HBBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define HBBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/hbbp_pkg.sv
// shared constants, operation codes and inter-module structs of the bit packer
// no dependencies
package hbbp_pkg;

	localparam int SYMBOLS      = 256;
	localparam int MAX_CODE_LEN = 32;

	localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int ENTRY_W = CODE_W + LEN_W;
	localparam int LEN_CAP = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int TOTAL_W = 40;
	localparam int PEND_W  = 7;
	localparam int ACC_W   = CODE_W + PEND_W;
	localparam int LA_W    = ACC_W + 1;
	localparam int NRES    = 4;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;

	// item entering the packing stage
	typedef struct packed {
		logic vld;
		logic flush;
		logic in_range;
	} pk_req_t;

	// table lookup result
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} lookup_t;

	// results of one item handed to the emitter
	typedef struct packed {
		logic               vld;
		logic [2:0]         nres;
		logic [8*NRES-1:0]  bytes;
		logic               byte_valid;
		logic               last;
		logic [TOTAL_W-1:0] total;
	} emit_t;

	// packer status for checking
	typedef struct packed {
		logic       flush_go;
		logic [2:0] pend_cnt;
	} pk_status_t;

endpackage

### rtl/hbbp_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module hbbp_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 38
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                wdata,
	input  logic                            re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/hbbp_table.sv
// code table: code and length ram plus per-entry valid bits
// depends on hbbp_pkg and hbbp_ram
module hbbp_table
	import hbbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [SYM_W-1:0]  waddr,
	input  logic [CODE_W-1:0] wcode,
	input  logic [LEN_W-1:0]  wlen,
	input  logic              re,
	input  logic [SYM_W-1:0]  raddr,
	output lookup_t           lk
);

	logic [SYMBOLS-1:0] valid_q;
	logic               rd_valid_q;
	logic [LEN_W-1:0]   wlen_cap;
	logic [ENTRY_W-1:0] rdata;

	// lengths beyond the cap saturate
	assign wlen_cap = (wlen > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : wlen;

	hbbp_ram #(
		.DEPTH(SYMBOLS),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata({wcode, wlen_cap}),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= valid_q[raddr];
			end
		end
	end

	// a never written entry reads as length zero
	assign lk.code = rdata[ENTRY_W-1:LEN_W];
	assign lk.len  = rd_valid_q ? rdata[LEN_W-1:0] : '0;

endmodule

### rtl/hbbp_packer.sv
// packing stage: merges looked-up code with pending bits, keeps block bit total
// depends on hbbp_pkg
module hbbp_packer
	import hbbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  pk_req_t    req,
	input  lookup_t    lk,
	input  logic       em_free,
	output logic       ready,
	output emit_t      ld,
	output pk_status_t st
);

	logic               vld_s1;
	logic               flush_s1;
	logic               in_range_s1;
	logic [PEND_W-1:0]  pend_bits_q;
	logic [2:0]         pend_cnt_q;
	logic [TOTAL_W-1:0] total_q;

	logic [LEN_W-1:0]   len_eff;
	logic [CODE_W:0]    mask;
	logic [ACC_W-1:0]   acc;
	logic [6:0]         n;
	logic [LA_W-1:0]    la;
	logic [2:0]         rem;
	logic [PEND_W-1:0]  pend_new;
	logic [2:0]         nbytes;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_new;
	logic [7:0]         fl_byte;
	logic [2:0]         nres;
	logic               go;

	always_comb begin
		len_eff   = in_range_s1 ? lk.len : '0;
		mask      = ((CODE_W+1)'(1) << len_eff) - (CODE_W+1)'(1);
		acc       = (ACC_W'(pend_bits_q) << len_eff) | ACC_W'(lk.code & mask[CODE_W-1:0]);
		n         = {4'b0, pend_cnt_q} + {1'b0, len_eff};
		// left-align the live bits so the oldest bit sits at the top
		la        = LA_W'(acc) << (7'(LA_W) - n);
		rem       = n[2:0];
		pend_new  = acc[PEND_W-1:0] & PEND_W'((8'd1 << rem) - 8'd1);
		nbytes    = n[5:3];
		sum       = {1'b0, total_q} + (TOTAL_W+1)'(len_eff);
		total_new = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
		fl_byte   = 8'({1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q}));
		nres      = flush_s1 ? 3'd1 : nbytes;
		go        = vld_s1 && ((nres == 3'd0) || em_free);
		ready     = !vld_s1 || go;
	end

	always_comb begin
		ld.vld        = go && (nres != 3'd0);
		ld.nres       = nres;
		ld.bytes      = flush_s1 ? {fl_byte, 24'h0} : la[LA_W-1:LA_W-8*NRES];
		ld.byte_valid = flush_s1 ? (pend_cnt_q != 3'd0) : 1'b1;
		ld.last       = flush_s1;
		ld.total      = flush_s1 ? total_q : total_new;
		st.flush_go   = go && flush_s1;
		st.pend_cnt   = pend_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			total_q     <= '0;
		end else begin
			if (ready) begin
				vld_s1 <= req.vld;
			end
			if (go) begin
				if (flush_s1) begin
					pend_bits_q <= '0;
					pend_cnt_q  <= '0;
					total_q     <= '0;
				end else begin
					pend_bits_q <= pend_new;
					pend_cnt_q  <= rem;
					total_q     <= total_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready) begin
			flush_s1    <= req.flush;
			in_range_s1 <= req.in_range;
		end
	end

endmodule

### rtl/hbbp_emitter.sv
// output buffer: holds up to four results of one item, sends one per cycle while m_tready is high
// depends on hbbp_pkg
module hbbp_emitter
	import hbbp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  emit_t        ld,
	output logic         free,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,
	output logic [0:0]   m_tuser,
	output logic         m_tlast
);

	logic [2:0]         cnt_q;
	logic [8*NRES-1:0]  bytes_q;
	logic               byte_valid_q;
	logic               last_q;
	logic [TOTAL_W-1:0] total_q;
	logic               load;
	logic               take;

	assign m_tvalid = (cnt_q != 3'd0);
	assign take     = m_tvalid && m_tready;
	assign free     = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && m_tready);
	assign load     = ld.vld && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= ld.nres;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q      <= ld.bytes;
			byte_valid_q <= ld.byte_valid;
			last_q       <= ld.last;
			total_q      <= ld.total;
		end else if (take) begin
			bytes_q <= {bytes_q[8*NRES-9:0], 8'h00};
		end
	end

	assign m_tdata = {total_q, bytes_q[8*NRES-1 -: 8]};
	assign m_tuser = byte_valid_q;
	assign m_tlast = last_q;

endmodule

### rtl/huffman_block_bit_packer.sv
// huffman block bit packer: a result leaves on m_* after the packing stage and output buffer
// s_tready is high every cycle the output buffer can absorb the next item, so writes and
// encodes that yield no byte flow at one per cycle while the packing stage is not stalled;
// flushes give a result; m_* sends one per cycle while m_tready is high, up to four per item
// reset clears the table valid bits, pending bits and bit total at once, no sweep
// depends on hbbp_pkg, hbbp_table, hbbp_ram, hbbp_packer, hbbp_emitter and the macros header
`include "huffman_block_bit_packer_macros.svh"

module huffman_block_bit_packer
	import hbbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input item stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // symbol[7:0], code_value[39:8], code_length[45:40], zero
	input  logic [1:0]  s_tuser,   // operation[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_byte[7:0], total_bits[47:8]
	output logic [0:0]  m_tuser,   // byte_valid[0]
	output logic        m_tlast    // is_last
);

	logic [7:0]        symbol;
	logic [CODE_W-1:0] code_value;
	logic [LEN_W-1:0]  code_length;
	logic [1:0]        operation;
	logic              accept;
	logic              in_range;
	logic              tbl_we;
	logic              tbl_re;
	lookup_t           lk;
	pk_req_t           req;
	emit_t             ld;
	pk_status_t        st;
	logic              em_free;

	// unpack the input transaction
	assign symbol      = s_tdata[7:0];
	assign code_value  = s_tdata[39:8];
	assign code_length = s_tdata[45:40];
	assign operation   = s_tuser;

	assign accept   = s_tvalid && s_tready;
	// symbols past the table end neither write nor emit bits
	assign in_range = ({1'b0, symbol} < 9'(SYMBOLS));
	assign tbl_we   = accept && (operation == OP_WRITE) && in_range;
	// the table read is only issued for an accepted encode, so a stalled lookup holds
	assign tbl_re   = accept && (operation == OP_ENCODE);

	// encodes and flushes move on to the packing stage, unknown operations are dropped
	assign req.vld      = accept && ((operation == OP_ENCODE) || (operation == OP_FLUSH));
	assign req.flush    = (operation == OP_FLUSH);
	assign req.in_range = in_range;

	hbbp_table u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (tbl_we),
		.waddr (symbol[SYM_W-1:0]),
		.wcode (code_value),
		.wlen  (code_length),
		.re    (tbl_re),
		.raddr (symbol[SYM_W-1:0]),
		.lk    (lk)
	);

	// packing stage consumes the registered lookup alongside the item registered at acceptance
	hbbp_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.lk     (lk),
		.em_free(em_free),
		.ready  (s_tready),
		.ld     (ld),
		.st     (st)
	);

	// output buffer decouples the result stream from the packing stage
	hbbp_emitter u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.ld      (ld),
		.free    (em_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// an empty flush carries a zero byte
	`HBBP_ASSERT_NOW(a_empty_flush_zero, clk, arst_n, m_tvalid && m_tlast && !m_tuser[0], m_tdata[7:0] == 8'h00, "empty flush with nonzero byte")
	// a completed byte means at least eight bits in the block
	`HBBP_ASSERT_NOW(a_byte_total_min, clk, arst_n, m_tvalid && !m_tlast, m_tdata[47:8] >= 40'd8, "encode result with bit total below eight")
	// a flush leaves no pending bits behind
	`HBBP_ASSERT_NEXT(a_flush_clears, clk, arst_n, st.flush_go, st.pend_cnt == 3'd0, "pending bits survive a flush")

endmodule

### tb/packer_scoreboard_pkg.sv
// scoreboard for the huffman block bit packer: code table predictor and expected byte queue
// depends on hbbp_pkg for operation codes, field widths and the code length cap
package packer_scoreboard_pkg;
	import hbbp_pkg::*;

	// operation code the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct {
		logic [7:0]         out_byte;
		logic               byte_valid;
		logic               is_last;
		logic [TOTAL_W-1:0] total_bits;
	} packed_byte_t;

	class bitstream_scoreboard;
		logic [CODE_W-1:0]  code_tab [SYMBOLS];
		logic [LEN_W-1:0]   len_tab [SYMBOLS];
		logic [7:0]         part_bits;
		int                 part_cnt;
		logic [TOTAL_W-1:0] block_bits;
		packed_byte_t       expected_bytes [$];
		int                 mismatches;

		function new();
			foreach (len_tab[i]) begin
				len_tab[i]  = '0;
				code_tab[i] = '0;
			end
			part_bits  = '0;
			part_cnt   = 0;
			block_bits = '0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		// update the table and bit packer state for one accepted transaction
		function void note_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
			int           clen;
			packed_byte_t res;
			case (op)
				OP_WRITE: begin
					if (int'(sym) < SYMBOLS) begin
						code_tab[sym] = code;
						len_tab[sym]  = (len > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
					end
				end
				OP_ENCODE: begin
					clen = (int'(sym) < SYMBOLS) ? int'(len_tab[sym]) : 0;
					// every byte of this symbol reports the total after the whole code
					if (block_bits > TOTAL_MAX - clen)
						block_bits = TOTAL_MAX;
					else
						block_bits = block_bits + clen;
					for (int i = clen - 1; i >= 0; i--) begin
						part_bits = {part_bits[6:0], code_tab[sym][i]};
						part_cnt++;
						if (part_cnt == 8) begin
							res.out_byte   = part_bits;
							res.byte_valid = 1'b1;
							res.is_last    = 1'b0;
							res.total_bits = block_bits;
							expected_bytes = {expected_bytes, res};
							part_bits = '0;
							part_cnt  = 0;
						end
					end
				end
				OP_FLUSH: begin
					// partial byte left-aligned, empty flush gives a zero byte marked invalid
					res.out_byte   = part_bits << (8 - part_cnt);
					res.byte_valid = (part_cnt != 0);
					res.is_last    = 1'b1;
					res.total_bits = block_bits;
					expected_bytes = {expected_bytes, res};
					part_bits  = '0;
					part_cnt   = 0;
					block_bits = '0;
				end
				default: ;
			endcase
		endfunction

		// compare one accepted result with the oldest expected byte
		function void check_result(input logic [7:0] out_byte, input logic byte_valid,
			input logic is_last, input logic [TOTAL_W-1:0] total_bits);
			packed_byte_t want;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected result: byte %02h valid %b last %b total %0d",
						out_byte, byte_valid, is_last, total_bits);
				return;
			end
			want = expected_bytes.pop_front();
			if (out_byte !== want.out_byte || byte_valid !== want.byte_valid ||
				is_last !== want.is_last || total_bits !== want.total_bits) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("mismatch: expected byte %02h valid %b last %b total %0d, got byte %02h valid %b last %b total %0d",
						want.out_byte, want.byte_valid, want.is_last, want.total_bits,
						out_byte, byte_valid, is_last, total_bits);
			end
		endfunction
	endclass

endpackage

### tb/tb_top.sv
// top of the huffman block bit packer testbench: clock, reset, stream drivers and checking
// depends on hbbp_pkg, packer_scoreboard_pkg and the huffman_block_bit_packer rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hbbp_pkg::*;
	import packer_scoreboard_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 5;
	localparam int ITEMS_PER_PHASE = 112;
	// results are registered before they leave, a short settle covers stray outputs
	localparam int DRAIN_CYCLES    = 16;
	// cycles with work outstanding but no transaction on either side
	localparam int STALL_LIMIT     = 2000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;   // symbol[7:0], code_value[39:8], code_length[45:40], zero
	logic [1:0]  s_tuser  = '0;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // out_byte[7:0], total_bits[47:8]
	logic [0:0]  m_tuser;         // byte_valid[0]
	logic        m_tlast;         // is_last

	bitstream_scoreboard sb = new();

	// idling percentages, changed per phase by the stimulus
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int stall_cycles   = 0;

	// symbols whose table entry has been written, only these get encoded
	logic [SYM_W-1:0] written_syms [$];

	huffman_block_bit_packer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #CLK_HALF clk = ~clk;

	// result side backpressure, redrawn every falling edge
	always @(negedge clk) begin
		if (arst_n)
			m_tready = ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: both handshakes sampled at the rising edge, plus the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_item(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[45:40]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[7:0], m_tuser[0], m_tlast, m_tdata[47:8]);
			// only count while something is offered or still owed
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				!(s_tvalid || sb.pending() != 0))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// offer one transaction, called and returning at a falling edge
	task automatic send_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
		input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {2'b00, len, code, sym};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
		input logic [LEN_W-1:0] len);
		send_item(OP_WRITE, sym, code, len);
		written_syms = {written_syms, sym};
	endtask

	task automatic encode_sym(input logic [SYM_W-1:0] sym);
		send_item(OP_ENCODE, sym, $urandom(), LEN_W'($urandom_range(63)));
	endtask

	task automatic flush_block();
		send_item(OP_FLUSH, SYM_W'($urandom_range(255)), $urandom(),
			LEN_W'($urandom_range(63)));
	endtask

	initial begin : stimulus
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		int                pick;
		int                len_pick;
		int                n;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, no idling
		send_item(OP_UNUSED, 8'hA5, 32'hFFFF_FFFF, 6'd63);   // ignored operation
		flush_block();                                        // empty flush straight after reset
		write_entry(8'h00, 32'hFFFF_FFFF, 6'd32);             // longest code, all ones
		write_entry(8'hFF, 32'h0000_0000, 6'd1);              // single zero bit
		write_entry(8'h80, 32'hA5A5_A5A5, 6'd63);             // length saturates to the cap
		write_entry(8'h7F, 32'hFFFF_FFFF, 6'd0);              // zero length, emits nothing
		write_entry(8'h01, 32'hFFFF_FF81, 6'd7);              // junk above the code bits
		write_entry(8'h02, 32'h1234_5673, 6'd3);
		write_entry(8'h55, 32'hDEAD_BEEF, 6'd33);             // just above the cap
		encode_sym(8'h01);                                    // seven bits pending
		encode_sym(8'h00);                                    // 39 bits, four bytes at once
		encode_sym(8'h7F);
		encode_sym(8'hFF);                                    // completes a byte
		encode_sym(8'h02);
		flush_block();                                        // flush with a partial byte
		flush_block();                                        // empty flush after a block
		encode_sym(8'h80);
		encode_sym(8'h55);
		encode_sym(8'h02);
		encode_sym(8'hFF);
		send_item(OP_UNUSED, 8'h00, 32'h0000_0000, 6'd0);
		flush_block();

		// random part in four idling phases
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 86;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 86;
				end
				default: begin
					send_idle_pct  = 32;
					recv_stall_pct = 32;
				end
			endcase
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 12) begin
					// table rewrite, lengths biased toward the extremes
					len_pick = $urandom_range(99);
					if (len_pick < 5)
						len = 6'd0;
					else if (len_pick < 12)
						len = LEN_W'($urandom_range(63, 33));
					else if (len_pick < 20)
						len = 6'd32;
					else
						len = LEN_W'($urandom_range(31, 1));
					sym  = SYM_W'($urandom_range(255));
					code = $urandom();
					write_entry(sym, code, len);
					n++;
				end else if (pick < 20) begin
					flush_block();
					n++;
				end else if (pick < 23) begin
					// ignored by the block, does not count
					send_item(OP_UNUSED, SYM_W'($urandom_range(255)), $urandom(),
						LEN_W'($urandom_range(63)));
				end else begin
					encode_sym(written_syms[$urandom_range(written_syms.size() - 1)]);
					n++;
				end
			end
		end

		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
